FILE: design/gsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the geometry string parser
// Character codes, token classes, queue sizing and result layout.
// ----------------------------------------------------------------------------
package gsp_pkg;

   localparam int VALUE_BITS = 16;
   localparam int ACC_EXT_W  = VALUE_BITS + 4;
   localparam int VAL_W      = 17;
   localparam int WIDTH_W    = 16;
   localparam int MASK_W     = 6;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;

   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam int RSP_FIELD_W = MASK_W + 3 * VAL_W + WIDTH_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   localparam logic [VALUE_BITS-1:0] MAG_LIMIT = '1;
   localparam logic [ACC_EXT_W-1:0]  RADIX     = ACC_EXT_W'(10);

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_EQ    = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_UPX   = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LOWX  = 8'h78;

   localparam logic [MASK_W-1:0] MASK_X    = 6'h01;
   localparam logic [MASK_W-1:0] MASK_Y    = 6'h02;
   localparam logic [MASK_W-1:0] MASK_W_B  = 6'h04;
   localparam logic [MASK_W-1:0] MASK_H    = 6'h08;
   localparam logic [MASK_W-1:0] MASK_XNEG = 6'h10;
   localparam logic [MASK_W-1:0] MASK_YNEG = 6'h20;

   typedef enum logic [2:0] {
      CLS_NUL,
      CLS_DIGIT,
      CLS_PLUS,
      CLS_MINUS,
      CLS_LOWX,
      CLS_UPX,
      CLS_EQ,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      cls_type              cls;
      logic [DIGIT_W-1:0]   digit;
   } tok_type;

endpackage

`default_nettype wire

FILE: design/geometry_string_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// geometry_string_parser: streaming geometry string parser
// Parses [=][W][x|X H][+|-X[+|-Y]] one byte per transfer, one result per
// zero terminator.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle, back to back, while its token
// queue has room. A classifier queues each byte as a token; the parse engine
// retires one token per cycle unless a terminator waits on a stalled result,
// the digit step (accumulator times ten plus digit, saturated at 65535) being
// the update that sets that rate. A result is valid from the clock edge after
// its terminator is transferred in when no token or earlier result waits ahead
// of it. A stalled result output holds only the next terminator; other
// characters keep flowing until the queue fills.
module geometry_string_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [7:0] char_code
   input  wire logic [7:0]                    req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [5:0] field_mask, [22:6] x_offset, [39:23] y_offset,
   // [55:40] area_width, [72:56] area_height, [79:73] zero
   output logic [gsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] rejected
   output logic                               rsp_tuser
);
   import gsp_pkg::*;

   logic    tok_valid;
   logic    tok_ready;
   tok_type tok;

   gsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .tok_valid  (tok_valid),
      .tok_ready  (tok_ready),
      .tok        (tok)
   );

   gsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (tok_valid),
      .tok_ready  (tok_ready),
      .tok        (tok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: design/gsp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_front: character classifier and token queue
// Accepts one byte per transfer, maps it to a token class and holds it in a
// short queue until the parser takes it.
// ----------------------------------------------------------------------------
module gsp_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [7:0]      req_tdata,
   output logic                 tok_valid,
   input  wire logic            tok_ready,
   output gsp_pkg::tok_type     tok
);
   import gsp_pkg::*;

   tok_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   tok_type              cls_tok;
   logic                 push;
   logic                 pop;

   always_comb begin
      cls_tok.digit = DIGIT_W'(req_tdata - CHAR_ZERO);
      if (req_tdata inside {[CHAR_ZERO:CHAR_NINE]}) begin
         cls_tok.cls = CLS_DIGIT;
      end else begin
         case (req_tdata)
            CHAR_NUL:   cls_tok.cls = CLS_NUL;
            CHAR_PLUS:  cls_tok.cls = CLS_PLUS;
            CHAR_MINUS: cls_tok.cls = CLS_MINUS;
            CHAR_LOWX:  cls_tok.cls = CLS_LOWX;
            CHAR_UPX:   cls_tok.cls = CLS_UPX;
            CHAR_EQ:    cls_tok.cls = CLS_EQ;
            default:    cls_tok.cls = CLS_OTHER;
         endcase
      end
   end

   assign req_tready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign tok_valid  = (count_ff != '0);
   assign pop        = tok_valid && tok_ready;
   assign tok        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls_tok;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("token queue count exceeds depth");

endmodule

`default_nettype wire

FILE: design/gsp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_back: geometry parse engine and result register
// Steps the parse phase on each token, accumulates digits and emits the
// field mask and values at the terminator, or zeroed fields when rejected or empty.
// ----------------------------------------------------------------------------
module gsp_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           tok_valid,
   output logic                                tok_ready,
   input  gsp_pkg::tok_type                    tok,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [gsp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser
);
   import gsp_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_LEAD,
      PH_WIDTH,
      PH_HEIGHT,
      PH_XOFF,
      PH_YOFF,
      PH_DEAD
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [VALUE_BITS-1:0]     acc_ff, acc_in;
   logic                      nsign_ff, nsign_in;
   logic                      pneg_ff, pneg_in;
   logic                      consumed_ff, consumed_in;
   logic [MASK_W-1:0]         mask_ff, mask_in;
   logic [WIDTH_W-1:0]        width_ff, width_in;
   logic signed [VAL_W-1:0]   height_ff, height_in;
   logic signed [VAL_W-1:0]   x_ff, x_in;
   logic signed [VAL_W-1:0]   y_ff, y_in;
   logic                      err_ff, err_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_rej_ff, rsp_rej_in;

   logic                      fire;
   logic                      is_nul;
   logic                      is_sign;
   logic [ACC_EXT_W-1:0]      sum;
   logic [VALUE_BITS-1:0]     acc_dig;
   logic [VAL_W-1:0]          mag;
   logic signed [VAL_W-1:0]   sval;

   assign is_nul    = (tok.cls == CLS_NUL);
   assign is_sign   = (tok.cls inside {CLS_PLUS, CLS_MINUS});
   assign fire      = tok_valid && (!is_nul || !rsp_valid_ff || rsp_tready);
   assign tok_ready = fire;

   assign sum     = ACC_EXT_W'(acc_ff) * RADIX + ACC_EXT_W'(tok.digit);
   assign acc_dig = (sum > ACC_EXT_W'(MAG_LIMIT)) ? MAG_LIMIT : VALUE_BITS'(sum);
   assign mag     = VAL_W'(acc_ff);
   assign sval    = (nsign_ff ^ pneg_ff) ? signed'(VAL_W'(0) - mag) : signed'(mag);

   always_comb begin
      logic       empty;
      logic       do_lead;
      logic       do_after;
      logic [1:0] level;

      empty        = 1'b0;
      do_lead      = 1'b0;
      do_after     = 1'b0;
      level        = 2'd0;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      nsign_in     = nsign_ff;
      pneg_in      = pneg_ff;
      consumed_in  = consumed_ff;
      mask_in      = mask_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      err_in       = err_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (fire) begin
         case (phase_ff)
            PH_FIRST: begin
               if (is_nul) begin
                  empty = 1'b1;
               end else if (tok.cls == CLS_EQ) begin
                  phase_in = PH_LEAD;
               end else begin
                  do_lead = 1'b1;
               end
            end
            PH_LEAD: begin
               do_lead = 1'b1;
            end
            PH_WIDTH: begin
               if (tok.cls == CLS_DIGIT) begin
                  acc_in      = acc_dig;
                  consumed_in = 1'b1;
               end else begin
                  width_in = WIDTH_W'(acc_ff);
                  mask_in  = mask_ff | MASK_W_B;
                  do_after = 1'b1;
                  level    = 2'd0;
               end
            end
            PH_HEIGHT, PH_XOFF, PH_YOFF: begin
               if (tok.cls == CLS_DIGIT) begin
                  acc_in      = acc_dig;
                  consumed_in = 1'b1;
               end else if (!consumed_ff) begin
                  if (is_sign) begin
                     nsign_in    = (tok.cls == CLS_MINUS);
                     consumed_in = 1'b1;
                  end else begin
                     err_in   = 1'b1;
                     phase_in = PH_DEAD;
                  end
               end else begin
                  do_after = 1'b1;
                  case (phase_ff)
                     PH_HEIGHT: begin
                        height_in = sval;
                        mask_in   = mask_ff | MASK_H;
                        level     = 2'd1;
                     end
                     PH_XOFF: begin
                        x_in    = sval;
                        mask_in = mask_ff | MASK_X | (pneg_ff ? MASK_XNEG : '0);
                        level   = 2'd2;
                     end
                     default: begin
                        y_in    = sval;
                        mask_in = mask_ff | MASK_Y | (pneg_ff ? MASK_YNEG : '0);
                        level   = 2'd3;
                     end
                  endcase
               end
            end
            default: begin
               err_in   = 1'b1;
               phase_in = PH_DEAD;
            end
         endcase

         if (do_lead) begin
            acc_in      = '0;
            nsign_in    = 1'b0;
            pneg_in     = 1'b0;
            consumed_in = 1'b0;
            case (tok.cls)
               CLS_PLUS, CLS_MINUS: begin
                  phase_in = PH_XOFF;
                  pneg_in  = (tok.cls == CLS_MINUS);
               end
               CLS_LOWX: begin
                  phase_in = PH_HEIGHT;
               end
               CLS_DIGIT: begin
                  phase_in    = PH_WIDTH;
                  acc_in      = VALUE_BITS'(tok.digit);
                  consumed_in = 1'b1;
               end
               default: begin
                  err_in   = 1'b1;
                  phase_in = PH_DEAD;
               end
            endcase
         end

         if (do_after && !is_nul) begin
            acc_in      = '0;
            nsign_in    = 1'b0;
            pneg_in     = 1'b0;
            consumed_in = 1'b0;
            if (level == 2'd0 && (tok.cls == CLS_LOWX || tok.cls == CLS_UPX)) begin
               phase_in = PH_HEIGHT;
            end else if (level <= 2'd1 && is_sign) begin
               phase_in = PH_XOFF;
               pneg_in  = (tok.cls == CLS_MINUS);
            end else if (level == 2'd2 && is_sign) begin
               phase_in = PH_YOFF;
               pneg_in  = (tok.cls == CLS_MINUS);
            end else begin
               err_in   = 1'b1;
               phase_in = PH_DEAD;
            end
         end

         if (is_nul) begin
            rsp_valid_in = 1'b1;
            rsp_rej_in   = err_in;
            if (err_in || empty) begin
               rsp_data_in = '0;
            end else begin
               rsp_data_in = {RSP_PAD_W'(0), height_in, width_in, y_in, x_in, mask_in};
            end
            phase_in    = PH_FIRST;
            acc_in      = '0;
            nsign_in    = 1'b0;
            pneg_in     = 1'b0;
            consumed_in = 1'b0;
            mask_in     = '0;
            width_in    = '0;
            height_in   = '0;
            x_in        = '0;
            y_in        = '0;
            err_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         acc_ff       <= '0;
         nsign_ff     <= 1'b0;
         pneg_ff      <= 1'b0;
         consumed_ff  <= 1'b0;
         mask_ff      <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         nsign_ff     <= nsign_in;
         pneg_ff      <= pneg_in;
         consumed_ff  <= consumed_in;
         mask_ff      <= mask_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_rej_ff;

   a_dead_has_error: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEAD) |-> err_ff)
      else $error("dead phase without error flag");

   a_reject_clears_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rej_ff) |-> (rsp_data_ff == '0))
      else $error("rejected result carries field data");

   a_term_restarts: assert property (@(posedge clock) disable iff (reset)
      (fire && is_nul) |=> (phase_ff == PH_FIRST && !err_ff && mask_ff == '0
                            && rsp_valid_ff))
      else $error("terminator did not restart the parser");

   a_xneg_needs_x: assert property (@(posedge clock) disable iff (reset)
      ((mask_ff & MASK_XNEG) != '0) |-> ((mask_ff & MASK_X) != '0))
      else $error("x negative bit without x bit");

endmodule

`default_nettype wire

FILE: dv/gsp_checker.sv
// ----------------------------------------------------------------------------
// gsp_checker: result predictor and scoreboard for the geometry string parser
// Follows every character transfer into the parser with its own copy of the
// parse state, queues the result each terminator should give, and compares
// every result transfer field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module gsp_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [gsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          rsp_tuser,
   output int                            failures,
   output int                            pending
);
   import gsp_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_LEAD,
      PH_WIDTH,
      PH_HEIGHT,
      PH_XOFF,
      PH_YOFF,
      PH_DEAD
   } parse_phase_type;

   typedef struct packed {
      logic [MASK_W-1:0]  mask;
      logic [VAL_W-1:0]   x_off;
      logic [VAL_W-1:0]   y_off;
      logic [WIDTH_W-1:0] width;
      logic [VAL_W-1:0]   height;
      logic               rejected;
   } geometry_type;

   parse_phase_type   phase;
   int unsigned       digits_acc;
   bit                number_neg;
   bit                lead_neg;
   bit                have_any;
   bit                malformed;
   logic [MASK_W-1:0] found;
   logic [WIDTH_W-1:0] held_w;
   logic [VAL_W-1:0]  held_h;
   logic [VAL_W-1:0]  held_x;
   logic [VAL_W-1:0]  held_y;
   geometry_type      geometry_q[$];

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic bit is_sign(input logic [7:0] c);
      return c == CHAR_PLUS || c == CHAR_MINUS;
   endfunction

   function automatic logic [VAL_W-1:0] field_value();
      logic [VAL_W-1:0] mag;
      mag = VAL_W'(digits_acc);
      return (number_neg != lead_neg) ? -mag : mag;
   endfunction

   task automatic clear_parse();
      phase      = PH_FIRST;
      digits_acc = 0;
      number_neg = 0;
      lead_neg   = 0;
      have_any   = 0;
      malformed  = 0;
      found      = '0;
      held_w     = '0;
      held_h     = '0;
      held_x     = '0;
      held_y     = '0;
   endtask

   task automatic reject();
      malformed = 1;
      phase     = PH_DEAD;
   endtask

   task automatic push_digit(input logic [7:0] c);
      int unsigned v;
      v = digits_acc * 10 + int'(c - CHAR_ZERO);
      digits_acc = (v > MAG_LIMIT) ? MAG_LIMIT : v;
      have_any   = 1;
   endtask

   task automatic open_field(input parse_phase_type ph, input bit neg);
      phase      = ph;
      digits_acc = 0;
      number_neg = 0;
      lead_neg   = neg;
      have_any   = 0;
   endtask

   // level: 0 after width, 1 after height, 2 after x, 3 after y
   task automatic after_field(input logic [7:0] c, input int level);
      if (c == CHAR_NUL) begin
         return;
      end
      if (level == 0 && (c == CHAR_LOWX || c == CHAR_UPX)) begin
         open_field(PH_HEIGHT, 0);
      end else if (level <= 1 && is_sign(c)) begin
         open_field(PH_XOFF, c == CHAR_MINUS);
      end else if (level == 2 && is_sign(c)) begin
         open_field(PH_YOFF, c == CHAR_MINUS);
      end else begin
         reject();
      end
   endtask

   task automatic lead_char(input logic [7:0] c);
      if (is_sign(c)) begin
         open_field(PH_XOFF, c == CHAR_MINUS);
      end else if (c == CHAR_LOWX) begin
         open_field(PH_HEIGHT, 0);
      end else if (is_digit(c)) begin
         open_field(PH_WIDTH, 0);
         push_digit(c);
      end else begin
         reject();
      end
   endtask

   task automatic take_char(input logic [7:0] c);
      bit           empty;
      geometry_type g;
      empty = 0;
      case (phase)
         PH_FIRST: begin
            if (c == CHAR_NUL) begin
               empty = 1;
            end else if (c == CHAR_EQ) begin
               phase = PH_LEAD;
            end else begin
               lead_char(c);
            end
         end
         PH_LEAD: begin
            lead_char(c);
         end
         PH_WIDTH: begin
            if (is_digit(c)) begin
               push_digit(c);
            end else begin
               held_w = WIDTH_W'(digits_acc);
               found  |= MASK_W_B;
               after_field(c, 0);
            end
         end
         PH_HEIGHT, PH_XOFF, PH_YOFF: begin
            if (is_digit(c)) begin
               push_digit(c);
            end else if (!have_any) begin
               if (is_sign(c)) begin
                  number_neg = (c == CHAR_MINUS);
                  have_any   = 1;
               end else begin
                  reject();
               end
            end else if (phase == PH_HEIGHT) begin
               held_h = field_value();
               found  |= MASK_H;
               after_field(c, 1);
            end else if (phase == PH_XOFF) begin
               held_x = field_value();
               found  |= MASK_X | (lead_neg ? MASK_XNEG : '0);
               after_field(c, 2);
            end else begin
               held_y = field_value();
               found  |= MASK_Y | (lead_neg ? MASK_YNEG : '0);
               after_field(c, 3);
            end
         end
         default: begin
            reject();
         end
      endcase

      if (c == CHAR_NUL) begin
         g          = '0;
         g.rejected = malformed;
         if (!malformed && !empty) begin
            g.mask   = found;
            g.x_off  = held_x;
            g.y_off  = held_y;
            g.width  = held_w;
            g.height = held_h;
         end
         geometry_q.push_back(g);
         clear_parse();
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 'h%0h actual 'h%0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      geometry_type want;
      if (reset) begin
         clear_parse();
         geometry_q.delete();
         failures = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            take_char(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (geometry_q.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none actual 'h%0h/%0b",
                        $time, rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               want = geometry_q.pop_front();
               check_field("field_mask", want.mask, rsp_tdata[5:0]);
               check_field("x_offset", want.x_off, rsp_tdata[22:6]);
               check_field("y_offset", want.y_off, rsp_tdata[39:23]);
               check_field("area_width", want.width, rsp_tdata[55:40]);
               check_field("area_height", want.height, rsp_tdata[72:56]);
               check_field("rejected", want.rejected, rsp_tuser);
               check_field("pad", 0, rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W]);
            end
         end
      end
      pending = geometry_q.size();
   end

endmodule

FILE: dv/tb_geometry_string_parser.sv
// ----------------------------------------------------------------------------
// tb_geometry_string_parser: testbench top for the geometry string parser
// Streams directed and random geometry strings into the parser in bursts,
// stalls the result side on its own pattern, and reports the verdict from
// the failure and pending counts of the attached checker.
// ----------------------------------------------------------------------------
module tb_geometry_string_parser;
   import gsp_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   int                    failures;
   int                    pending;

   logic [7:0]            geom_text[$];
   int                    burst_left = 0;
   int                    stall_mode = 0;
   int                    stall_left = 0;

   geometry_string_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   gsp_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .failures   (failures),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(10, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_left % 4 == 0);
         default: rsp_tready <= (stall_left % 16 > 11);
      endcase
   end

   task automatic send_char(input logic [7:0] c);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
      end
      send_char(CHAR_NUL);
   endtask

   function automatic logic [7:0] any_sign();
      return $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
   endfunction

   function automatic logic [7:0] any_symbol();
      case ($urandom_range(0, 6))
         0, 1: return CHAR_ZERO + 8'($urandom_range(0, 9));
         2: return any_sign();
         3: return CHAR_LOWX;
         4: return CHAR_UPX;
         5: return CHAR_EQ;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic add_number();
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      repeat (n) geom_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   // extra sign is optional; a lone sign stands for zero
   task automatic add_signed_part();
      bit signed_lead;
      signed_lead = ($urandom_range(0, 9) < 3);
      if (signed_lead) begin
         geom_text.push_back(any_sign());
      end
      if (!signed_lead || $urandom_range(0, 4) != 0) begin
         add_number();
      end
   endtask

   task automatic make_geometry();
      bit has_width;
      geom_text.delete();
      if ($urandom_range(0, 3) == 0) begin
         geom_text.push_back(CHAR_EQ);
      end
      has_width = ($urandom_range(0, 9) < 7);
      if (has_width) begin
         add_number();
      end
      if ($urandom_range(0, 9) < 6) begin
         geom_text.push_back((has_width && $urandom_range(0, 1)) ? CHAR_UPX : CHAR_LOWX);
         add_signed_part();
      end
      if ($urandom_range(0, 9) < 6) begin
         geom_text.push_back(any_sign());
         add_signed_part();
         if ($urandom_range(0, 9) < 6) begin
            geom_text.push_back(any_sign());
            add_signed_part();
         end
      end
   endtask

   initial begin
      int counted;
      int strings;
      int kind;
      int pos;
      counted = 0;
      strings = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_text("");
      send_text("=");
      send_text("X1");
      send_text("x");
      send_text("99999X-+7");
      send_text("-+");
      send_text("=1+2-3q");

      while (counted < 650 || strings < 60) begin
         kind = $urandom_range(0, 9);
         if (kind <= 7) begin
            make_geometry();
            if (kind == 7) begin
               pos = $urandom_range(0, geom_text.size());
               geom_text.insert(pos, ($urandom_range(0, 1) == 0) ? any_symbol()
                                                                : 8'($urandom_range(1, 255)));
            end
            counted += geom_text.size() + 1;
         end else begin
            geom_text.delete();
            repeat ($urandom_range(1, 8)) begin
               geom_text.push_back((kind == 8) ? any_symbol() : 8'($urandom_range(1, 255)));
            end
            counted += geom_text.size() + 1;
         end
         foreach (geom_text[i]) send_char(geom_text[i]);
         send_char(CHAR_NUL);
         strings++;
      end

      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/gsp_pkg.sv
design/gsp_front.sv
design/gsp_back.sv
design/geometry_string_parser.sv
dv/gsp_checker.sv
dv/tb_geometry_string_parser.sv
